// File: rtl/vcc_pkg.sv
// ----------------------------------------------------------------------------
// vcc_pkg: shared definitions of the vending controller
// Request, status and register codes, the operating mode and the structs
// that travel between the register bank, the controller and the top level.
// ----------------------------------------------------------------------------
package vcc_pkg;

   // Request codes
   localparam logic [1:0] REQ_SELECT = 2'd0;
   localparam logic [1:0] REQ_COIN   = 2'd1;
   localparam logic [1:0] REQ_CANCEL = 2'd2;
   localparam logic [1:0] REQ_REFILL = 2'd3;

   // Product codes
   localparam logic [1:0] PROD_COFFEE    = 2'd0;
   localparam logic [1:0] PROD_CHOCOLATE = 2'd1;
   localparam logic [1:0] PROD_MILK      = 2'd2;
   localparam logic [1:0] PROD_NONE      = 2'd3;

   // Coin codes
   localparam logic [2:0] COIN_TENTH = 3'd0;
   localparam logic [2:0] COIN_FIFTH = 3'd1;
   localparam logic [2:0] COIN_HALF  = 3'd2;
   localparam logic [2:0] COIN_ONE   = 3'd3;
   localparam logic [2:0] COIN_TWO   = 3'd4;
   localparam logic [2:0] COIN_FIVE  = 3'd5;
   localparam logic [2:0] COIN_TEN   = 3'd6;
   localparam logic [2:0] COIN_NONE  = 3'd7;

   // Status codes
   localparam logic [2:0] ST_SELECTED  = 3'd0;
   localparam logic [2:0] ST_MORE_DUE  = 3'd1;
   localparam logic [2:0] ST_VENDED    = 3'd2;
   localparam logic [2:0] ST_CANCELLED = 3'd3;
   localparam logic [2:0] ST_NO_STOCK  = 3'd4;
   localparam logic [2:0] ST_REFILLED  = 3'd5;
   localparam logic [2:0] ST_REJECTED  = 3'd6;

   // Register indexes
   localparam logic [2:0] CSR_PRICE_COFFEE     = 3'd0;
   localparam logic [2:0] CSR_PRICE_CHOCOLATE  = 3'd1;
   localparam logic [2:0] CSR_PRICE_MILK       = 3'd2;
   localparam logic [2:0] CSR_REFILL_COFFEE    = 3'd3;
   localparam logic [2:0] CSR_REFILL_CHOCOLATE = 3'd4;
   localparam logic [2:0] CSR_REFILL_MILK      = 3'd5;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'b01,
      MODE_COLLECT = 2'b10
   } mode_type;

   typedef struct packed {
      logic [7:0] price_coffee;
      logic [7:0] price_chocolate;
      logic [7:0] price_milk;
      logic [4:0] refill_coffee;
      logic [4:0] refill_chocolate;
      logic [4:0] refill_milk;
   } cfg_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [1:0] product_sel;
      logic       with_milk;
      logic [2:0] coin_code;
   } item_type;

   typedef struct packed {
      logic       ten;
      logic       five;
      logic [1:0] two;
      logic       one;
      logic       half;
      logic [1:0] fifth;
      logic       tenth;
   } change_type;

   typedef struct packed {
      logic [2:0] status;
      logic [9:0] amount_paid;
      logic [9:0] return_total;
      change_type change;
   } result_type;

endpackage

// File: rtl/vcc_csr.sv
// ----------------------------------------------------------------------------
// vcc_csr: configuration registers
// Holds the three prices and the three refill levels, written one at a time.
// ----------------------------------------------------------------------------
module vcc_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [2:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output vcc_pkg::cfg_type cfg
);

   vcc_pkg::cfg_type cfg_ff;
   vcc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            vcc_pkg::CSR_PRICE_COFFEE:     cfg_in.price_coffee     = csr_wdata;
            vcc_pkg::CSR_PRICE_CHOCOLATE:  cfg_in.price_chocolate  = csr_wdata;
            vcc_pkg::CSR_PRICE_MILK:       cfg_in.price_milk       = csr_wdata;
            vcc_pkg::CSR_REFILL_COFFEE:    cfg_in.refill_coffee    = csr_wdata[4:0];
            vcc_pkg::CSR_REFILL_CHOCOLATE: cfg_in.refill_chocolate = csr_wdata[4:0];
            vcc_pkg::CSR_REFILL_MILK:      cfg_in.refill_milk      = csr_wdata[4:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.price_coffee     <= 8'd15;
         cfg_ff.price_chocolate  <= 8'd21;
         cfg_ff.price_milk       <= 8'd3;
         cfg_ff.refill_coffee    <= 5'd10;
         cfg_ff.refill_chocolate <= 5'd10;
         cfg_ff.refill_milk      <= 5'd20;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/vcc_fsm.sv
// ----------------------------------------------------------------------------
// vcc_fsm: vending controller state and event logic
// Holds the mode, the selection, the money counters and the stock, and works
// out the result of one registered event. State moves on when advance is high.
// ----------------------------------------------------------------------------
module vcc_fsm (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  vcc_pkg::item_type   item,
   input  vcc_pkg::cfg_type    cfg,
   output vcc_pkg::result_type result
);

   vcc_pkg::mode_type mode_ff, mode_in;
   logic [1:0]        chosen_product_ff, chosen_product_in;
   logic              chosen_milk_ff, chosen_milk_in;
   logic [8:0]        amount_due_ff, amount_due_in;
   logic [9:0]        paid_sum_ff, paid_sum_in;
   logic [4:0]        stock_coffee_ff, stock_coffee_in;
   logic [4:0]        stock_chocolate_ff, stock_chocolate_in;
   logic [4:0]        stock_milk_ff, stock_milk_in;

   logic              sel_milk;
   logic [4:0]        sel_stock;
   logic [7:0]        sel_price;
   logic [8:0]        due_sum;
   logic [6:0]        coin_val;
   logic [9:0]        paid_new;
   logic [9:0]        left;
   logic              vend;

   // Greedy change. The change never exceeds ten euro, so seven bits suffice.
   function automatic vcc_pkg::change_type greedy_change(input logic [6:0] v);
      logic [6:0]          r;
      vcc_pkg::change_type c;
      r = v;
      c = '0;
      if (r >= 7'd100) begin
         c.ten = 1'b1;
         r = r - 7'd100;
      end
      if (r >= 7'd50) begin
         c.five = 1'b1;
         r = r - 7'd50;
      end
      if (r >= 7'd40) begin
         c.two = 2'd2;
         r = r - 7'd40;
      end else if (r >= 7'd20) begin
         c.two = 2'd1;
         r = r - 7'd20;
      end
      if (r >= 7'd10) begin
         c.one = 1'b1;
         r = r - 7'd10;
      end
      if (r >= 7'd5) begin
         c.half = 1'b1;
         r = r - 7'd5;
      end
      if (r >= 7'd4) begin
         c.fifth = 2'd2;
         r = r - 7'd4;
      end else if (r >= 7'd2) begin
         c.fifth = 2'd1;
         r = r - 7'd2;
      end
      c.tenth = r[0];
      return c;
   endfunction

   function automatic logic [4:0] take_one(input logic [4:0] s);
      return (s != 5'd0) ? s - 5'd1 : s;
   endfunction

   // Milk ordered with milk counts as plain milk.
   assign sel_milk = item.with_milk && (item.product_sel != vcc_pkg::PROD_MILK);

   always_comb begin
      case (item.product_sel)
         vcc_pkg::PROD_COFFEE: begin
            sel_stock = stock_coffee_ff;
            sel_price = cfg.price_coffee;
         end
         vcc_pkg::PROD_CHOCOLATE: begin
            sel_stock = stock_chocolate_ff;
            sel_price = cfg.price_chocolate;
         end
         default: begin
            sel_stock = stock_milk_ff;
            sel_price = cfg.price_milk;
         end
      endcase
   end

   assign due_sum = {1'b0, sel_price} + (sel_milk ? {1'b0, cfg.price_milk} : 9'd0);

   always_comb begin
      case (item.coin_code)
         vcc_pkg::COIN_TENTH: coin_val = 7'd1;
         vcc_pkg::COIN_FIFTH: coin_val = 7'd2;
         vcc_pkg::COIN_HALF:  coin_val = 7'd5;
         vcc_pkg::COIN_ONE:   coin_val = 7'd10;
         vcc_pkg::COIN_TWO:   coin_val = 7'd20;
         vcc_pkg::COIN_FIVE:  coin_val = 7'd50;
         vcc_pkg::COIN_TEN:   coin_val = 7'd100;
         default:             coin_val = 7'd0;
      endcase
   end

   assign paid_new = paid_sum_ff + {3'd0, coin_val};
   assign vend     = paid_new >= {1'b0, amount_due_ff};
   assign left     = paid_new - {1'b0, amount_due_ff};

   always_comb begin
      mode_in            = mode_ff;
      chosen_product_in  = chosen_product_ff;
      chosen_milk_in     = chosen_milk_ff;
      amount_due_in      = amount_due_ff;
      paid_sum_in        = paid_sum_ff;
      stock_coffee_in    = stock_coffee_ff;
      stock_chocolate_in = stock_chocolate_ff;
      stock_milk_in      = stock_milk_ff;

      result.status       = vcc_pkg::ST_REJECTED;
      result.amount_paid  = paid_sum_ff;
      result.return_total = 10'd0;
      result.change       = '0;

      case (item.req_type)
         vcc_pkg::REQ_SELECT: begin
            if (mode_ff == vcc_pkg::MODE_IDLE && item.product_sel != vcc_pkg::PROD_NONE) begin
               if (sel_stock == 5'd0 || (sel_milk && stock_milk_ff == 5'd0)) begin
                  result.status = vcc_pkg::ST_NO_STOCK;
               end else begin
                  chosen_product_in  = item.product_sel;
                  chosen_milk_in     = sel_milk;
                  amount_due_in      = due_sum;
                  paid_sum_in        = 10'd0;
                  mode_in            = vcc_pkg::MODE_COLLECT;
                  result.status      = vcc_pkg::ST_SELECTED;
                  result.amount_paid = 10'd0;
               end
            end
         end
         vcc_pkg::REQ_COIN: begin
            if (mode_ff == vcc_pkg::MODE_COLLECT && item.coin_code != vcc_pkg::COIN_NONE) begin
               result.amount_paid = paid_new;
               if (vend) begin
                  if (chosen_product_ff == vcc_pkg::PROD_COFFEE) begin
                     stock_coffee_in = take_one(stock_coffee_ff);
                  end
                  if (chosen_product_ff == vcc_pkg::PROD_CHOCOLATE) begin
                     stock_chocolate_in = take_one(stock_chocolate_ff);
                  end
                  if (chosen_product_ff == vcc_pkg::PROD_MILK || chosen_milk_ff) begin
                     stock_milk_in = take_one(stock_milk_ff);
                  end
                  result.return_total = left;
                  result.change       = greedy_change(left[6:0]);
                  mode_in             = vcc_pkg::MODE_IDLE;
                  paid_sum_in         = 10'd0;
                  amount_due_in       = 9'd0;
                  result.status       = vcc_pkg::ST_VENDED;
               end else begin
                  paid_sum_in   = paid_new;
                  result.status = vcc_pkg::ST_MORE_DUE;
               end
            end
         end
         vcc_pkg::REQ_CANCEL: begin
            if (mode_ff == vcc_pkg::MODE_COLLECT) begin
               result.return_total = paid_sum_ff;
               mode_in             = vcc_pkg::MODE_IDLE;
               paid_sum_in         = 10'd0;
               amount_due_in       = 9'd0;
               result.status       = vcc_pkg::ST_CANCELLED;
            end
         end
         default: begin
            if (mode_ff == vcc_pkg::MODE_IDLE) begin
               stock_coffee_in    = cfg.refill_coffee;
               stock_chocolate_in = cfg.refill_chocolate;
               stock_milk_in      = cfg.refill_milk;
               result.status      = vcc_pkg::ST_REFILLED;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= vcc_pkg::MODE_IDLE;
         chosen_product_ff  <= vcc_pkg::PROD_COFFEE;
         chosen_milk_ff     <= 1'b0;
         amount_due_ff      <= 9'd0;
         paid_sum_ff        <= 10'd0;
         stock_coffee_ff    <= 5'd10;
         stock_chocolate_ff <= 5'd10;
         stock_milk_ff      <= 5'd20;
      end else if (advance) begin
         mode_ff            <= mode_in;
         chosen_product_ff  <= chosen_product_in;
         chosen_milk_ff     <= chosen_milk_in;
         amount_due_ff      <= amount_due_in;
         paid_sum_ff        <= paid_sum_in;
         stock_coffee_ff    <= stock_coffee_in;
         stock_chocolate_ff <= stock_chocolate_in;
         stock_milk_ff      <= stock_milk_in;
      end
   end

endmodule

// File: rtl/vending_controller_with_change.sv
// ----------------------------------------------------------------------------
// vending_controller_with_change: top level of the vending controller
// A request waits in the request register; the response register is loaded
// from it when free or being emptied, and rsp_valid rises with that load.
// Throughput: one transaction per cycle unless rsp_ready stalls; it is set
// by the single pass of event logic between the two registers.
// Reset (synchronous, active high) gives the idle mode, default prices and
// refill levels and full stock; no clearing pass is needed.
// ----------------------------------------------------------------------------
module vending_controller_with_change (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_type,
   input  logic [1:0] req_product_sel,
   input  logic       req_with_milk,
   input  logic [2:0] req_coin_code,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_status,
   output logic [9:0] rsp_amount_paid,
   output logic [9:0] rsp_return_total,
   output logic       rsp_count_ten,
   output logic       rsp_count_five,
   output logic [1:0] rsp_count_two,
   output logic       rsp_count_one,
   output logic       rsp_count_half,
   output logic [1:0] rsp_count_fifth,
   output logic       rsp_count_tenth,
   input  logic       csr_we,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_wdata
);

   vcc_pkg::cfg_type    cfg;
   vcc_pkg::item_type   item_ff;
   vcc_pkg::result_type result;
   vcc_pkg::result_type result_ff;
   logic                in_valid_ff, in_valid_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                advance;

   vcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   vcc_fsm u_fsm (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item_ff),
      .cfg     (cfg),
      .result  (result)
   );

   // The registered event moves on whenever the response register is free
   // or is being emptied in the same cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff.req_type    <= req_type;
         item_ff.product_sel <= req_product_sel;
         item_ff.with_milk   <= req_with_milk;
         item_ff.coin_code   <= req_coin_code;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = result_ff.status;
   assign rsp_amount_paid  = result_ff.amount_paid;
   assign rsp_return_total = result_ff.return_total;
   assign rsp_count_ten    = result_ff.change.ten;
   assign rsp_count_five   = result_ff.change.five;
   assign rsp_count_two    = result_ff.change.two;
   assign rsp_count_one    = result_ff.change.one;
   assign rsp_count_half   = result_ff.change.half;
   assign rsp_count_fifth  = result_ff.change.fifth;
   assign rsp_count_tenth  = result_ff.change.tenth;

`ifndef ASSERT_OFF
   // The coins handed back on a vend add up to the change reported.
   a_change_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status == vcc_pkg::ST_VENDED |->
         ({9'd0, rsp_count_ten} * 10'd100) + ({9'd0, rsp_count_five} * 10'd50)
         + ({8'd0, rsp_count_two} * 10'd20) + ({9'd0, rsp_count_one} * 10'd10)
         + ({9'd0, rsp_count_half} * 10'd5) + ({8'd0, rsp_count_fifth} * 10'd2)
         + {9'd0, rsp_count_tenth} == rsp_return_total)
      else $error("change coins do not add up to the returned amount");

   a_no_coins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status != vcc_pkg::ST_VENDED |->
         result_ff.change == '0)
      else $error("change coins reported without a vend");

   a_refund: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status == vcc_pkg::ST_CANCELLED |->
         rsp_return_total == rsp_amount_paid)
      else $error("cancel does not refund the amount paid");

   a_no_return: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && result_ff.status != vcc_pkg::ST_VENDED
         && result_ff.status != vcc_pkg::ST_CANCELLED |->
         rsp_return_total == 10'd0)
      else $error("money returned outside a vend or cancel");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("registered transaction did not reach the response register");
`endif

endmodule
